FILE: src/ffsa_pkg.sv
// shared types and constants of the first-fit segment allocator
`default_nettype none
package ffsa_pkg;

    localparam int KIND_W   = 2;
    localparam int FIELD_W  = 16;
    localparam int STATUS_W = 3;
    localparam int OP_W     = 5;

    localparam logic [FIELD_W-1:0] REGION_RESET = 16'd1024;

    localparam logic [KIND_W-1:0] KIND_ALLOC    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FREE_ALL = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FIT    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 3'd4;

    localparam logic [OP_W-1:0] OP_NOP         = 5'd0;
    localparam logic [OP_W-1:0] OP_LATCH       = 5'd1;
    localparam logic [OP_W-1:0] OP_SET_STATUS  = 5'd2;
    localparam logic [OP_W-1:0] OP_REBUILD     = 5'd3;
    localparam logic [OP_W-1:0] OP_SCAN_START  = 5'd4;
    localparam logic [OP_W-1:0] OP_SCAN_NEXT   = 5'd5;
    localparam logic [OP_W-1:0] OP_CAPTURE     = 5'd6;
    localparam logic [OP_W-1:0] OP_ALLOC_EXACT = 5'd7;
    localparam logic [OP_W-1:0] OP_SHIFT_UP    = 5'd8;
    localparam logic [OP_W-1:0] OP_SPLIT_HI    = 5'd9;
    localparam logic [OP_W-1:0] OP_SPLIT_LO    = 5'd10;
    localparam logic [OP_W-1:0] OP_FREE_PREV   = 5'd11;
    localparam logic [OP_W-1:0] OP_FREE_NEXT   = 5'd12;
    localparam logic [OP_W-1:0] OP_MERGE       = 5'd13;
    localparam logic [OP_W-1:0] OP_SHIFT_DN    = 5'd14;
    localparam logic [OP_W-1:0] OP_SHRINK      = 5'd15;
    localparam logic [OP_W-1:0] OP_FINISH      = 5'd16;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [STATUS_W-1:0] status;
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              size_zero;
        logic              hit;
        logic              last;
        logic              exact;
        logic              full;
        logic              up_more;
        logic              cur_free;
        logic              dn_more;
        logic              out_free;
    } t_flags;

endpackage
`default_nettype wire

FILE: src/ffsa_req_if.sv
// request channel: valid, ready and request payload
`default_nettype none
interface ffsa_req_if;
    import ffsa_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [FIELD_W-1:0]  request_size;
    logic [FIELD_W-1:0]  block_address;

    modport source (output valid, output kind, output request_size,
                    output block_address, input ready);
    modport sink (input valid, input kind, input request_size,
                  input block_address, output ready);
endinterface
`default_nettype wire

FILE: src/ffsa_rsp_if.sv
// result channel: valid, ready and result payload
`default_nettype none
interface ffsa_rsp_if;
    import ffsa_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  address;
    logic [FIELD_W-1:0]  free_bytes;
    logic                leak;

    modport source (output valid, output status, output address,
                    output free_bytes, output leak, input ready);
    modport sink (input valid, input status, input address,
                  input free_bytes, input leak, output ready);
endinterface
`default_nettype wire

FILE: src/first_fit_segment_allocator_unit.sv
// top level of the first-fit segment allocator
`default_nettype none
// First-fit allocator over a table of up to MAX_SEGMENTS segments kept in a
// simple dual-port memory (one read and one write per cycle). One request is in
// work at a time. An allocate scans the table one segment per cycle up to the
// first fit; unless the fit is exact or the table is full, it then moves
// every later entry up one place per cycle and writes the split pair. A free
// scans to the matching offset and, if that segment is in use, reads both
// neighbors, writes the merged segment and moves later entries down, by one
// place for each merged neighbor, one entry per cycle. The segments scanned
// and the entries moved together never exceed the segment count. A finished
// result can wait on a stalled output. Free-all, zero-size and unused-kind
// requests neither scan nor move entries. After reset the table is rebuilt
// before the first request is taken. A finished result waits in an output
// register while the next request is taken. region_size takes effect in the
// table at the next free-all.
module first_fit_segment_allocator_unit #(
    parameter int MAX_SEGMENTS = 32,
    parameter int ADDR_BITS    = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    ffsa_req_if.sink                          i_req,
    ffsa_rsp_if.source                        o_rsp,
    input  wire logic                         i_cfg_we,
    input  wire logic [ffsa_pkg::FIELD_W-1:0] i_cfg_wdata
);
    import ffsa_pkg::*;

    logic [FIELD_W-1:0] r_region_size;
    t_cmd               cmd;
    t_flags             flags;
    logic               in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_size <= REGION_RESET;
        end else if (i_cfg_we) begin
            r_region_size <= i_cfg_wdata;
        end
    end

    assign i_req.ready = in_ready;

    ffsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_flags    (flags),
        .o_cmd      (cmd),
        .o_in_ready (in_ready)
    );

    ffsa_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .ADDR_BITS    (ADDR_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_flags      (flags),
        .i_kind       (i_req.kind),
        .i_req_size   (i_req.request_size),
        .i_block_addr (i_req.block_address),
        .i_region     (r_region_size),
        .i_rsp_ready  (o_rsp.ready),
        .o_rsp_valid  (o_rsp.valid),
        .o_status     (o_rsp.status),
        .o_address    (o_rsp.address),
        .o_free_bytes (o_rsp.free_bytes),
        .o_leak       (o_rsp.leak)
    );

endmodule
`default_nettype wire

FILE: src/ffsa_ctrl.sv
// sequencer for scan, split, merge and shift steps of the allocator
`default_nettype none
module ffsa_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire ffsa_pkg::t_flags i_flags,
    output ffsa_pkg::t_cmd       o_cmd,
    output logic                 o_in_ready
);
    import ffsa_pkg::*;

    localparam logic [3:0] S_INIT      = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_DISPATCH  = 4'd2;
    localparam logic [3:0] S_SCAN      = 4'd3;
    localparam logic [3:0] S_ALLOC     = 4'd4;
    localparam logic [3:0] S_SHIFT_UP  = 4'd5;
    localparam logic [3:0] S_SPLIT_LO  = 4'd6;
    localparam logic [3:0] S_FREE      = 4'd7;
    localparam logic [3:0] S_FREE_NEXT = 4'd8;
    localparam logic [3:0] S_MERGE     = 4'd9;
    localparam logic [3:0] S_SHIFT_DN  = 4'd10;
    localparam logic [3:0] S_DONE      = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.op      = OP_NOP;
        o_cmd.status  = ST_OK;
        o_in_ready    = 1'b0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.op = OP_REBUILD;
                n_state  = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LATCH;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_flags.kind == KIND_ALLOC && i_flags.size_zero) begin
                    o_cmd.op     = OP_SET_STATUS;
                    o_cmd.status = ST_ZERO_SIZE;
                    n_state      = S_DONE;
                end else if (i_flags.kind == KIND_ALLOC || i_flags.kind == KIND_FREE) begin
                    o_cmd.op = OP_SCAN_START;
                    n_state  = S_SCAN;
                end else if (i_flags.kind == KIND_FREE_ALL) begin
                    o_cmd.op = OP_REBUILD;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (i_flags.hit) begin
                    o_cmd.op = OP_CAPTURE;
                    n_state  = (i_flags.kind == KIND_ALLOC) ? S_ALLOC : S_FREE;
                end else if (!i_flags.last) begin
                    o_cmd.op = OP_SCAN_NEXT;
                end else begin
                    o_cmd.op     = OP_SET_STATUS;
                    o_cmd.status = (i_flags.kind == KIND_ALLOC) ? ST_NO_FIT : ST_BAD_FREE;
                    n_state      = S_DONE;
                end
            end
            S_ALLOC: begin
                if (i_flags.exact) begin
                    o_cmd.op = OP_ALLOC_EXACT;
                    n_state  = S_DONE;
                end else if (i_flags.full) begin
                    o_cmd.op     = OP_SET_STATUS;
                    o_cmd.status = ST_FULL;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_SHIFT_UP;
                end
            end
            S_SHIFT_UP: begin
                if (i_flags.up_more) begin
                    o_cmd.op = OP_SHIFT_UP;
                end else begin
                    o_cmd.op = OP_SPLIT_HI;
                    n_state  = S_SPLIT_LO;
                end
            end
            S_SPLIT_LO: begin
                o_cmd.op = OP_SPLIT_LO;
                n_state  = S_DONE;
            end
            S_FREE: begin
                if (i_flags.cur_free) begin
                    o_cmd.op     = OP_SET_STATUS;
                    o_cmd.status = ST_BAD_FREE;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.op = OP_FREE_PREV;
                    n_state  = S_FREE_NEXT;
                end
            end
            S_FREE_NEXT: begin
                o_cmd.op = OP_FREE_NEXT;
                n_state  = S_MERGE;
            end
            S_MERGE: begin
                o_cmd.op = OP_MERGE;
                n_state  = S_SHIFT_DN;
            end
            S_SHIFT_DN: begin
                if (i_flags.dn_more) begin
                    o_cmd.op = OP_SHIFT_DN;
                end else begin
                    o_cmd.op = OP_SHRINK;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (i_flags.out_free) begin
                    o_cmd.op = OP_FINISH;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: src/ffsa_dp.sv
// segment table memory, scan and merge arithmetic, result register
`default_nettype none
module ffsa_dp #(
    parameter int MAX_SEGMENTS = 32,
    parameter int ADDR_BITS    = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire ffsa_pkg::t_cmd                  i_cmd,
    output ffsa_pkg::t_flags                     o_flags,
    input  wire logic [ffsa_pkg::KIND_W-1:0]     i_kind,
    input  wire logic [ffsa_pkg::FIELD_W-1:0]    i_req_size,
    input  wire logic [ffsa_pkg::FIELD_W-1:0]    i_block_addr,
    input  wire logic [ffsa_pkg::FIELD_W-1:0]    i_region,
    input  wire logic                            i_rsp_ready,
    output logic                                 o_rsp_valid,
    output logic [ffsa_pkg::STATUS_W-1:0]        o_status,
    output logic [ffsa_pkg::FIELD_W-1:0]         o_address,
    output logic [ffsa_pkg::FIELD_W-1:0]         o_free_bytes,
    output logic                                 o_leak
);
    import ffsa_pkg::*;

    localparam int W  = ADDR_BITS;
    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int EW = 2 * W + 1;

    logic [EW-1:0] mem [MAX_SEGMENTS];
    logic [EW-1:0] r_rd;

    logic          wr_en, rd_en;
    logic [CW-1:0] wr_ptr, rd_ptr;
    logic [EW-1:0] wr_data;

    logic [W-1:0] rd_off, rd_len;
    logic         rd_free;

    logic [KIND_W-1:0]   r_kind, n_kind;
    logic [W-1:0]        r_size, n_size;
    logic [W-1:0]        r_baddr, n_baddr;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [W-1:0]        r_addr, n_addr;
    logic [CW-1:0]       r_count, n_count;
    logic [W-1:0]        r_free_total, n_free_total;
    logic [CW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_pos, n_pos;
    logic [CW-1:0]       r_k, n_k;
    logic [1:0]          r_m, n_m;
    logic [W-1:0]        r_cur_off, n_cur_off, r_cur_len, n_cur_len;
    logic                r_cur_free, n_cur_free;
    logic [W-1:0]        r_prev_off, n_prev_off, r_prev_len, n_prev_len;
    logic                r_prev_free, n_prev_free;
    logic [W-1:0]        r_next_len, n_next_len;
    logic                r_next_free, n_next_free;
    logic                r_ovalid, n_ovalid;
    logic [STATUS_W-1:0] r_o_status, n_o_status;
    logic [FIELD_W-1:0]  r_o_addr, n_o_addr, r_o_free, n_o_free;
    logic                r_o_leak, n_o_leak;

    logic [CW-1:0] merge_pos;
    logic [W-1:0]  merge_off, merge_len;
    logic [1:0]    merge_cnt;
    logic          out_free;

    assign rd_off  = r_rd[W-1:0];
    assign rd_len  = r_rd[2*W-1:W];
    assign rd_free = r_rd[2*W];

    assign merge_pos = r_prev_free ? r_pos - CW'(1) : r_pos;
    assign merge_off = r_prev_free ? r_prev_off : r_cur_off;
    assign merge_len = (r_prev_free ? r_prev_len : '0) + r_cur_len
                     + (r_next_free ? r_next_len : '0);
    assign merge_cnt = {1'b0, r_prev_free} + {1'b0, r_next_free};
    assign out_free  = !r_ovalid || i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_ptr[IW-1:0]] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_ptr[IW-1:0]];
        end
    end

    always_comb begin
        o_flags.kind      = r_kind;
        o_flags.size_zero = (r_size == '0);
        o_flags.hit       = (r_kind == KIND_ALLOC) ? (rd_free && rd_len >= r_size)
                                                   : (rd_off == r_baddr);
        o_flags.last      = ({1'b0, r_idx} + (CW + 1)'(1)) >= {1'b0, r_count};
        o_flags.exact     = (r_cur_len == r_size);
        o_flags.full      = (r_count == CW'(MAX_SEGMENTS));
        o_flags.up_more   = {1'b0, r_k} > ({1'b0, r_pos} + (CW + 1)'(1));
        o_flags.cur_free  = r_cur_free;
        o_flags.dn_more   = (r_m != 2'd0)
                         && (({1'b0, r_k} + (CW + 1)'(r_m)) < {1'b0, r_count});
        o_flags.out_free  = out_free;
    end

    always_comb begin
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        wr_ptr       = '0;
        rd_ptr       = '0;
        wr_data      = r_rd;
        n_kind       = r_kind;
        n_size       = r_size;
        n_baddr      = r_baddr;
        n_status     = r_status;
        n_addr       = r_addr;
        n_count      = r_count;
        n_free_total = r_free_total;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_k          = r_k;
        n_m          = r_m;
        n_cur_off    = r_cur_off;
        n_cur_len    = r_cur_len;
        n_cur_free   = r_cur_free;
        n_prev_off   = r_prev_off;
        n_prev_len   = r_prev_len;
        n_prev_free  = r_prev_free;
        n_next_len   = r_next_len;
        n_next_free  = r_next_free;
        n_ovalid     = r_ovalid && !i_rsp_ready;
        n_o_status   = r_o_status;
        n_o_addr     = r_o_addr;
        n_o_free     = r_o_free;
        n_o_leak     = r_o_leak;
        unique case (i_cmd.op)
            OP_NOP: begin
            end
            OP_LATCH: begin
                n_kind   = i_kind;
                n_size   = W'(i_req_size);
                n_baddr  = W'(i_block_addr);
                n_status = ST_OK;
                n_addr   = '0;
            end
            OP_SET_STATUS: begin
                n_status = i_cmd.status;
            end
            OP_REBUILD: begin
                wr_en        = 1'b1;
                wr_ptr       = '0;
                wr_data      = {1'b1, W'(i_region), {W{1'b0}}};
                n_count      = CW'(1);
                n_free_total = W'(i_region);
            end
            OP_SCAN_START: begin
                n_idx  = '0;
                rd_en  = 1'b1;
                rd_ptr = '0;
            end
            OP_SCAN_NEXT: begin
                n_idx  = r_idx + CW'(1);
                rd_en  = 1'b1;
                rd_ptr = r_idx + CW'(1);
            end
            OP_CAPTURE: begin
                n_cur_off  = rd_off;
                n_cur_len  = rd_len;
                n_cur_free = rd_free;
                n_pos      = r_idx;
                n_k        = r_count;
                rd_en      = 1'b1;
                rd_ptr     = (r_kind == KIND_ALLOC) ? r_count - CW'(1) : r_idx - CW'(1);
            end
            OP_ALLOC_EXACT: begin
                wr_en        = 1'b1;
                wr_ptr       = r_pos;
                wr_data      = {1'b0, r_cur_len, r_cur_off};
                n_free_total = r_free_total - r_size;
                n_addr       = r_cur_off;
            end
            OP_SHIFT_UP: begin
                wr_en   = 1'b1;
                wr_ptr  = r_k;
                wr_data = r_rd;
                n_k     = r_k - CW'(1);
                rd_en   = 1'b1;
                rd_ptr  = r_k - CW'(2);
            end
            OP_SPLIT_HI: begin
                wr_en   = 1'b1;
                wr_ptr  = r_pos + CW'(1);
                wr_data = {1'b1, r_cur_len - r_size, r_cur_off + r_size};
            end
            OP_SPLIT_LO: begin
                wr_en        = 1'b1;
                wr_ptr       = r_pos;
                wr_data      = {1'b0, r_size, r_cur_off};
                n_count      = r_count + CW'(1);
                n_free_total = r_free_total - r_size;
                n_addr       = r_cur_off;
            end
            OP_FREE_PREV: begin
                n_prev_free  = (r_pos != '0) && rd_free;
                n_prev_off   = rd_off;
                n_prev_len   = rd_len;
                n_free_total = r_free_total + r_cur_len;
                rd_en        = 1'b1;
                rd_ptr       = r_pos + CW'(1);
            end
            OP_FREE_NEXT: begin
                n_next_free = (({1'b0, r_pos} + (CW + 1)'(1)) < {1'b0, r_count}) && rd_free;
                n_next_len  = rd_len;
            end
            OP_MERGE: begin
                wr_en   = 1'b1;
                wr_ptr  = merge_pos;
                wr_data = {1'b1, merge_len, merge_off};
                n_k     = merge_pos + CW'(1);
                n_m     = merge_cnt;
                rd_en   = 1'b1;
                rd_ptr  = merge_pos + CW'(1) + CW'(merge_cnt);
            end
            OP_SHIFT_DN: begin
                wr_en   = 1'b1;
                wr_ptr  = r_k;
                wr_data = r_rd;
                n_k     = r_k + CW'(1);
                rd_en   = 1'b1;
                rd_ptr  = r_k + CW'(1) + CW'(r_m);
            end
            OP_SHRINK: begin
                n_count = r_count - CW'(r_m);
            end
            OP_FINISH: begin
                n_ovalid   = 1'b1;
                n_o_status = r_status;
                n_o_addr   = FIELD_W'(r_addr);
                n_o_free   = FIELD_W'(r_free_total);
                n_o_leak   = (r_free_total != W'(i_region));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= CW'(1);
            r_ovalid <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_size       <= n_size;
        r_baddr      <= n_baddr;
        r_status     <= n_status;
        r_addr       <= n_addr;
        r_free_total <= n_free_total;
        r_idx        <= n_idx;
        r_pos        <= n_pos;
        r_k          <= n_k;
        r_m          <= n_m;
        r_cur_off    <= n_cur_off;
        r_cur_len    <= n_cur_len;
        r_cur_free   <= n_cur_free;
        r_prev_off   <= n_prev_off;
        r_prev_len   <= n_prev_len;
        r_prev_free  <= n_prev_free;
        r_next_len   <= n_next_len;
        r_next_free  <= n_next_free;
        r_o_status   <= n_o_status;
        r_o_addr     <= n_o_addr;
        r_o_free     <= n_o_free;
        r_o_leak     <= n_o_leak;
    end

    assign o_rsp_valid  = r_ovalid;
    assign o_status     = r_o_status;
    assign o_address    = r_o_addr;
    assign o_free_bytes = r_o_free;
    assign o_leak       = r_o_leak;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != '0 && r_count <= CW'(MAX_SEGMENTS))
        else $error("segment count out of range");
    a_finish_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == OP_FINISH |-> out_free)
        else $error("result loaded while output busy");
    a_split_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == OP_SPLIT_LO |=> r_count == $past(r_count) + CW'(1))
        else $error("split did not add a segment");
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(i_cmd.op == OP_FINISH))
        else $error("result valid without finish");
`endif

endmodule
`default_nettype wire

FILE: bench/tb_first_fit_segment_allocator_unit.sv
// first-fit segment allocator testbench: directed and random requests checked against a table model
`default_nettype none
module tb_first_fit_segment_allocator_unit;
    import ffsa_pkg::*;

    localparam int NSEG = 32;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] size;
        logic [FIELD_W-1:0] baddr;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FIELD_W-1:0]  address;
        logic [FIELD_W-1:0]  free_bytes;
        logic                leak;
    } t_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [FIELD_W-1:0] cfg_wdata = '0;

    ffsa_req_if req_if();
    ffsa_rsp_if rsp_if();

    first_fit_segment_allocator_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_if.sink), .o_rsp(rsp_if.source),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // allocator model state
    logic [FIELD_W-1:0] m_region;
    logic [FIELD_W-1:0] m_off [NSEG];
    logic [FIELD_W-1:0] m_len [NSEG];
    logic               m_free [NSEG];
    int                 m_count;
    logic [FIELD_W-1:0] m_total;

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    int errors = 0;
    int n_checked = 0;
    int n_status [8];

    function automatic void rebuild_table();
        for (int k = 0; k < NSEG; k++) begin
            m_off[k] = '0; m_len[k] = '0; m_free[k] = 1'b0;
        end
        m_len[0] = m_region;
        m_free[0] = 1'b1;
        m_count = 1;
        m_total = m_region;
    endfunction

    function automatic void drop_entry(int pos);
        for (int k = pos; k + 1 < m_count; k++) begin
            m_off[k] = m_off[k+1]; m_len[k] = m_len[k+1]; m_free[k] = m_free[k+1];
        end
        m_count--;
        m_off[m_count] = '0; m_len[m_count] = '0; m_free[m_count] = 1'b0;
    endfunction

    function automatic t_rsp predict_allocation(t_req r);
        t_rsp o;
        int i;
        bit done;
        o = '0;
        o.status = ST_OK;
        if (r.kind == KIND_ALLOC) begin
            done = 0;
            if (r.size == 0) begin
                o.status = ST_ZERO_SIZE;
                done = 1;
            end
            for (i = 0; i < m_count && !done; i++) begin
                if (m_free[i] && m_len[i] >= r.size) begin
                    done = 1;
                    if (m_len[i] > r.size && m_count >= NSEG) begin
                        o.status = ST_FULL;
                    end else begin
                        if (m_len[i] > r.size) begin
                            for (int k = m_count; k > i + 1; k--) begin
                                m_off[k] = m_off[k-1]; m_len[k] = m_len[k-1];
                                m_free[k] = m_free[k-1];
                            end
                            m_off[i+1] = m_off[i] + r.size;
                            m_len[i+1] = m_len[i] - r.size;
                            m_free[i+1] = 1'b1;
                            m_len[i] = r.size;
                            m_count++;
                        end
                        m_free[i] = 1'b0;
                        m_total = m_total - r.size;
                        o.address = m_off[i];
                    end
                end
            end
            if (!done) o.status = ST_NO_FIT;
        end else if (r.kind == KIND_FREE) begin
            o.status = ST_BAD_FREE;
            done = 0;
            for (i = 0; i < m_count && !done; i++) begin
                if (m_off[i] == r.baddr) begin
                    done = 1;
                    if (!m_free[i]) begin
                        o.status = ST_OK;
                        m_free[i] = 1'b1;
                        m_total = m_total + m_len[i];
                        i = 1;
                        while (i < m_count) begin
                            if (m_free[i-1] && m_free[i]) begin
                                m_len[i-1] = m_len[i-1] + m_len[i];
                                drop_entry(i);
                            end else begin
                                i++;
                            end
                        end
                    end
                end
            end
        end else if (r.kind == KIND_FREE_ALL) begin
            rebuild_table();
        end
        o.free_bytes = m_total;
        o.leak = (m_total != m_region);
        return o;
    endfunction

    // pick a segment start from the model table, or any value
    function automatic logic [FIELD_W-1:0] pick_free_addr();
        int idx;
        if ($urandom_range(0, 9) < 8) begin
            idx = $urandom_range(0, m_count - 1);
            return m_off[idx];
        end
        return FIELD_W'($urandom);
    endfunction

    // request driver: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_if.kind <= '0;
            req_if.request_size <= '0;
            req_if.block_address <= '0;
        end else if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                req_if.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                t_req r;
                r = pending_reqs.pop_front();
                req_if.valid <= 1'b1;
                req_if.kind <= r.kind;
                req_if.request_size <= r.size;
                req_if.block_address <= r.baddr;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // predict on each accepted transfer
    always @(posedge i_clk) begin
        if (i_rst_n && req_if.valid && req_if.ready) begin
            t_req r;
            r.kind = req_if.kind;
            r.size = req_if.request_size;
            r.baddr = req_if.block_address;
            expected_rsps = {expected_rsps, predict_allocation(r)};
        end
    end

    // result stall pattern
    int stall_phase = 0;
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (!i_rst_n) rsp_if.ready <= 1'b0;
        else if ((stall_phase / 300) % 3 == 0) rsp_if.ready <= 1'b1;
        else rsp_if.ready <= ($urandom_range(0, 3) != 0) || (stall_phase % 37 == 0);
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            t_rsp got, exp_r;
            got.status = rsp_if.status;
            got.address = rsp_if.address;
            got.free_bytes = rsp_if.free_bytes;
            got.leak = rsp_if.leak;
            if (expected_rsps.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                exp_r = expected_rsps.pop_front();
                n_checked++;
                n_status[exp_r.status]++;
                if (got.status !== exp_r.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_r.status, got.status);
                    errors++;
                end
                if (got.address !== exp_r.address) begin
                    $display("%0t: address expected %h actual %h", $time,
                             exp_r.address, got.address);
                    errors++;
                end
                if (got.free_bytes !== exp_r.free_bytes) begin
                    $display("%0t: free_bytes expected %h actual %h", $time,
                             exp_r.free_bytes, got.free_bytes);
                    errors++;
                end
                if (got.leak !== exp_r.leak) begin
                    $display("%0t: leak expected %0b actual %0b", $time,
                             exp_r.leak, got.leak);
                    errors++;
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || req_if.valid || expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_region(logic [FIELD_W-1:0] v);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        m_region = v;
    endtask

    task automatic queue_req(logic [KIND_W-1:0] k, logic [FIELD_W-1:0] s,
                             logic [FIELD_W-1:0] a);
        t_req r;
        r.kind = k; r.size = s; r.baddr = a;
        pending_reqs = {pending_reqs, r};
    endtask

    // random phase; the model is only consulted for address picks, so pace it
    task automatic random_phase(int n, int max_size);
        int c;
        for (int j = 0; j < n; j++) begin
            c = $urandom_range(0, 99);
            while (pending_reqs.size() > 0 || expected_rsps.size() > 2) @(posedge i_clk);
            if (c < 50)
                queue_req(KIND_ALLOC, (c < 2) ? 16'd0 :
                          ((c < 4) ? FIELD_W'($urandom) : FIELD_W'($urandom_range(1, max_size))),
                          FIELD_W'($urandom));
            else if (c < 93)
                queue_req(KIND_FREE, FIELD_W'($urandom), pick_free_addr());
            else if (c < 97)
                queue_req(KIND_FREE_ALL, FIELD_W'($urandom), FIELD_W'($urandom));
            else
                queue_req(2'd3, FIELD_W'($urandom), FIELD_W'($urandom));
        end
    endtask

    initial begin
        m_region = REGION_RESET;
        rebuild_table();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        // directed
        queue_req(KIND_ALLOC, 16'd0, 16'd0);
        queue_req(KIND_ALLOC, 16'd100, 16'hFFFF);
        queue_req(KIND_ALLOC, 16'd924, 16'd0);
        queue_req(KIND_ALLOC, 16'd1, 16'd0);
        queue_req(KIND_ALLOC, 16'hFFFF, 16'd0);
        queue_req(KIND_FREE, 16'hFFFF, 16'd0);
        queue_req(KIND_FREE, 16'd0, 16'd0);
        queue_req(KIND_FREE, 16'd0, 16'd5);
        queue_req(KIND_FREE, 16'd0, 16'd100);
        queue_req(2'd3, 16'hFFFF, 16'hFFFF);
        queue_req(KIND_FREE_ALL, 16'hFFFF, 16'hFFFF);
        for (int j = 0; j < 33; j++) queue_req(KIND_ALLOC, 16'd1, 16'd0);
        queue_req(KIND_ALLOC, 16'd2000, 16'd0);
        queue_req(KIND_FREE, 16'd0, 16'd3);
        queue_req(KIND_FREE, 16'd0, 16'd2);
        wait_drained();

        random_phase(600, 80);
        wait_drained();
        write_region(16'hFFFF);
        queue_req(KIND_ALLOC, 16'd1, 16'd0);
        queue_req(KIND_FREE_ALL, 16'd0, 16'd0);
        random_phase(400, 8000);
        wait_drained();
        write_region(16'd1);
        queue_req(KIND_FREE_ALL, 16'd0, 16'd0);
        random_phase(100, 2);
        wait_drained();
        write_region(16'd0);
        queue_req(KIND_FREE_ALL, 16'd0, 16'd0);
        random_phase(60, 3);
        wait_drained();
        write_region(FIELD_W'($urandom_range(1, 65535)));
        queue_req(KIND_FREE_ALL, 16'd0, 16'd0);
        random_phase(600, 400);
        wait_drained();

        $display("checked %0d results: ok %0d, no fit %0d, table full %0d, bad free %0d, zero %0d",
                 n_checked, n_status[0], n_status[1], n_status[2], n_status[3], n_status[4]);
        $display("region sizes covered: reset, 65535, 1, 0 and one random value");
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire
